@@ hdl/qcsm_pkg.sv @@
// qcsm_pkg: shared types and constants for the quad coverage score map.
// No dependencies.
package qcsm_pkg;
  localparam int GRID_W_DEF = 256;
  localparam int GRID_H_DEF = 256;
  localparam int CW = 17;   // corner width
  localparam int QW = 16;   // score width
  localparam int NW = 17;   // output count width
  localparam int FW = 9;
  localparam int BW = 10;

  localparam logic [1:0] REG_MIN_NEW = 2'd0;
  localparam logic [1:0] REG_MAX_NEW = 2'd1;
  localparam logic [1:0] REG_MIN_BET = 2'd2;
  localparam logic [1:0] REG_BIAS    = 2'd3;

  // one classified request handed from front to back
  typedef struct packed {
    logic signed [CW-1:0] x0, y0, x1, y1, x2, y2, x3, y3;
    logic [QW-1:0]        q;
    logic [QW-1:0]        id;
    logic [12:0]          lox, hix, loy, hiy;
    logic                 empty_box;
  } quad_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_SCAN1, ST_DECIDE, ST_SCAN2, ST_DONE
  } back_state_t;

  typedef enum logic [1:0] {
    FS_IDLE, FS_AREA, FS_BOX, FS_PUSH
  } front_state_t;

  // floor(v/16)
  function automatic logic signed [CW-1:0] fl16(input logic signed [CW-1:0] v);
    fl16 = v >>> 4;
  endfunction
  // ceil(v/16); one extra bit so the top corner values do not wrap
  function automatic logic signed [CW-1:0] cl16(input logic signed [CW-1:0] v);
    logic signed [CW:0] w;
    w = {v[CW-1], v} + (CW+1)'(15);
    cl16 = CW'(w >>> 4);
  endfunction
endpackage

@@ hdl/qcsm_front.sv @@
// qcsm_front: accepts quads, assigns ids, orders corners, clips bounding box.
// Depends on qcsm_pkg.
module qcsm_front #(
  parameter int GRID_WIDTH  = qcsm_pkg::GRID_W_DEF,
  parameter int GRID_HEIGHT = qcsm_pkg::GRID_H_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [qcsm_pkg::CW-1:0] c1x, c1y, c2x, c2y, c3x, c3y, c4x, c4y,
  input  logic [qcsm_pkg::QW-1:0]      quality,
  output logic                        push,
  input  logic                        full,
  output qcsm_pkg::quad_t             qout
);
  import qcsm_pkg::*;
  front_state_t st, st_next;
  quad_t        r;
  logic [QW-1:0] next_id;
  logic signed [36:0] area;
  logic [1:0]   k;
  logic signed [CW-1:0] px [4];
  logic signed [CW-1:0] py [4];
  logic signed [CW-1:0] mnx, mxx, mny, mxy, flx, fly, clx, cly;
  logic signed [CW:0] t0, t1;
  logic signed [36:0] prod;
  logic [1:0] kn;

  assign px[0] = r.x0; assign px[1] = r.x1; assign px[2] = r.x2; assign px[3] = r.x3;
  assign py[0] = r.y0; assign py[1] = r.y1; assign py[2] = r.y2; assign py[3] = r.y3;
  assign kn = k + 2'd1;

  always_comb begin
    t0 = {px[kn][CW-1], px[kn]} - {px[k][CW-1], px[k]};
    t1 = {py[kn][CW-1], py[kn]} + {py[k][CW-1], py[k]};
    prod = 37'(t0) * 37'(t1);
  end

  always_comb begin
    mnx = r.x0; mxx = r.x0; mny = r.y0; mxy = r.y0;
    for (int i = 1; i < 4; i++) begin
      if (px[i] < mnx) mnx = px[i];
      if (px[i] > mxx) mxx = px[i];
      if (py[i] < mny) mny = py[i];
      if (py[i] > mxy) mxy = py[i];
    end
    flx = fl16(mnx); fly = fl16(mny); clx = cl16(mxx); cly = cl16(mxy);
  end

  always_comb begin
    st_next = st;
    unique case (st)
      FS_IDLE: if (start) st_next = FS_AREA;
      FS_AREA: if (k == 2'd3) st_next = FS_BOX;
      FS_BOX:  st_next = FS_PUSH;
      FS_PUSH: if (!full) st_next = FS_IDLE;
      default: st_next = FS_IDLE;
    endcase
  end

  assign busy = (st != FS_IDLE);
  assign push = (st == FS_PUSH) && !full;
  assign qout = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= FS_IDLE;
      next_id <= '0;
      k <= '0;
    end else begin
      st <= st_next;
      if (st == FS_IDLE && start) begin
        next_id <= next_id + 1'b1;
        k <= '0;
      end else if (st == FS_AREA) begin
        k <= k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st == FS_IDLE && start) begin
      r.x0 <= c1x; r.y0 <= c1y; r.x1 <= c2x; r.y1 <= c2y;
      r.x2 <= c3x; r.y2 <= c3y; r.x3 <= c4x; r.y3 <= c4y;
      r.q <= quality; r.id <= next_id;
      area <= '0;
    end else if (st == FS_AREA) begin
      area <= area + prod;
    end else if (st == FS_BOX) begin
      if (area > 0) begin
        r.x1 <= r.x3; r.y1 <= r.y3; r.x3 <= r.x1; r.y3 <= r.y1;
      end
      r.lox <= flx < 0 ? '0 : 13'(flx);
      r.loy <= fly < 0 ? '0 : 13'(fly);
      r.hix <= clx > CW'(GRID_WIDTH - 1)  ? 13'(GRID_WIDTH - 1)  : 13'(clx);
      r.hiy <= cly > CW'(GRID_HEIGHT - 1) ? 13'(GRID_HEIGHT - 1) : 13'(cly);
      r.empty_box <= (clx < 0) || (cly < 0) || (flx > CW'(GRID_WIDTH - 1)) ||
                     (fly > CW'(GRID_HEIGHT - 1)) || (flx > clx) || (fly > cly);
    end
  end
endmodule

@@ hdl/qcsm_fifo.sv @@
// qcsm_fifo: two-entry queue of classified quads between front and back.
// Depends on qcsm_pkg.
module qcsm_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  qcsm_pkg::quad_t din,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output qcsm_pkg::quad_t dout
);
  import qcsm_pkg::*;
  quad_t      mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign full = (cnt == 2'd2);
  assign nonempty = (cnt != 2'd0);
  assign dout = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
  always_ff @(posedge clk) if (push) mem[wp] <= din;
endmodule

@@ hdl/qcsm_back.sv @@
// qcsm_back: clears the map, runs both scans, gain test and result strobe.
// Depends on qcsm_pkg.
module qcsm_back #(
  parameter int GRID_WIDTH  = qcsm_pkg::GRID_W_DEF,
  parameter int GRID_HEIGHT = qcsm_pkg::GRID_H_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    nonempty,
  input  qcsm_pkg::quad_t         qin,
  output logic                    pop,
  output logic                    clearing,
  input  logic [qcsm_pkg::FW-1:0] min_new, max_new, min_bet,
  input  logic [qcsm_pkg::BW-1:0] bias,
  output logic                    done,
  output logic                    accepted,
  output logic [qcsm_pkg::QW-1:0] image_id,
  output logic [qcsm_pkg::NW-1:0] covered_cells, empty_cells, weaker_cells, written_cells
);
  import qcsm_pkg::*;
  localparam int XW = $clog2(GRID_WIDTH);
  localparam int YW = $clog2(GRID_HEIGHT);
  localparam int AW = XW + YW;
  localparam int CNW = AW + 1;

  back_state_t st, st_next;
  quad_t  cq;
  logic [12:0] cx, cy;
  logic [AW-1:0] clr;
  logic [CNW-1:0] tot, emp, wk, wr;
  logic keep;
  // pipeline: stage A address + inside, memory read from stage A, data used in stage B
  logic va, vb, ina, inb;
  logic [AW-1:0] aa, ab;
  logic last_issued, pa_last, pb_last;
  logic mvalid;
  logic [QW-1:0] mq;
  logic valid_mem [1<<AW];
  logic [QW-1:0] qual_mem [1<<AW];
  logic [QW-1:0] own_mem [1<<AW];
  logic scanning;
  logic signed [18:0] ccx, ccy;
  logic signed [CW-1:0] px [4];
  logic signed [CW-1:0] py [4];
  logic inside_c;
  logic wr_en;
  logic [CNW+FW-1:0] mtot0, mtot1, mtot2;

  assign px[0] = cq.x0; assign px[1] = cq.x1; assign px[2] = cq.x2; assign px[3] = cq.x3;
  assign py[0] = cq.y0; assign py[1] = cq.y1; assign py[2] = cq.y2; assign py[3] = cq.y3;
  assign scanning = (st == ST_SCAN1 || st == ST_SCAN2) && !last_issued;

  always_comb begin
    logic signed [19:0] ex, ey, dx, dy;
    logic signed [39:0] cr;
    ccx = {2'b0, cx, 4'd8};
    ccy = {2'b0, cy, 4'd8};
    inside_c = 1'b1;
    for (int k = 0; k < 4; k++) begin
      ex = 20'(px[(k+1)%4]) - 20'(px[k]);
      ey = 20'(py[(k+1)%4]) - 20'(py[k]);
      dx = 20'(ccx) - 20'(px[k]);
      dy = 20'(ccy) - 20'(py[k]);
      cr = 40'(ex) * 40'(dy) - 40'(ey) * 40'(dx);
      if (cr < 0) inside_c = 1'b0;
    end
  end

  function automatic logic keep_calc();
    logic lo, hi;
    lo = (CNW+FW)'({emp, 8'd0}) < mtot0;
    hi = ((CNW+FW)'({emp, 8'd0}) > mtot1) && (emp < tot);
    keep_calc = (tot == '0) || !((lo || hi) && ((CNW+FW)'({wk, 8'd0}) < mtot2));
  endfunction

  always_comb begin
    st_next = st;
    unique case (st)
      ST_CLEAR: if (clr == AW'((1 << AW) - 1)) st_next = ST_IDLE;
      ST_IDLE:  if (nonempty) st_next = qin.empty_box ? ST_DECIDE : ST_SCAN1;
      ST_SCAN1: if (last_issued && !va && !vb) st_next = ST_DECIDE;
      ST_DECIDE: st_next = (keep_calc() && !cq.empty_box) ? ST_SCAN2 : ST_DONE;
      ST_SCAN2: if (last_issued && !va && !vb) st_next = ST_DONE;
      ST_DONE:  st_next = ST_IDLE;
      default:  st_next = ST_IDLE;
    endcase
  end

  assign pop = (st == ST_IDLE) && nonempty;
  assign clearing = (st == ST_CLEAR);
  assign done = (st == ST_DONE);
  assign accepted = keep;
  assign image_id = cq.id;
  assign covered_cells = NW'(tot);
  assign empty_cells = NW'(emp);
  assign weaker_cells = NW'(wk);
  assign written_cells = NW'(wr);

  assign wr_en = (st == ST_SCAN2) && vb && inb && (!mvalid || mq < cq.q);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_CLEAR; clr <= '0; va <= 1'b0; vb <= 1'b0; keep <= 1'b0;
    end else begin
      st <= st_next;
      if (st == ST_CLEAR) clr <= clr + 1'b1;
      va <= scanning;
      vb <= va;
      if (st == ST_DECIDE) keep <= keep_calc();
    end
  end

  // multiplies for the gain test, registered from the counters
  always_ff @(posedge clk) begin
    mtot0 <= (CNW+FW)'(tot) * (CNW+FW)'(min_new);
    mtot1 <= (CNW+FW)'(tot) * (CNW+FW)'(max_new);
    mtot2 <= (CNW+FW)'(tot) * (CNW+FW)'(min_bet);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cq <= qin;
      cx <= qin.lox; cy <= qin.loy; last_issued <= 1'b0;
      tot <= '0; emp <= '0; wk <= '0; wr <= '0;
    end else if (st == ST_DECIDE) begin
      cx <= cq.lox; cy <= cq.loy; last_issued <= 1'b0;
    end else if (scanning) begin
      if (cx == cq.hix) begin
        cx <= cq.lox;
        if (cy == cq.hiy) last_issued <= 1'b1;
        else cy <= cy + 1'b1;
      end else cx <= cx + 1'b1;
    end
    ina <= inside_c;
    aa <= {cy[YW-1:0], cx[XW-1:0]};
    inb <= ina; ab <= aa;
    if (st == ST_SCAN1 && vb && inb) begin
      tot <= tot + 1'b1;
      if (!mvalid) emp <= emp + 1'b1;
      else if (27'(mq) * 27'(bias) < {3'b0, cq.q, 8'd0}) wk <= wk + 1'b1;
    end
    if (wr_en) wr <= wr + 1'b1;
  end

  // map memories: read in stage A, data used in stage B
  always_ff @(posedge clk) begin
    mvalid <= valid_mem[aa];
    mq <= qual_mem[aa];
    if (st == ST_CLEAR) valid_mem[clr] <= 1'b0;
    else if (wr_en) valid_mem[ab] <= 1'b1;
    if (wr_en) begin
      qual_mem[ab] <= cq.q;
      own_mem[ab] <= cq.id;
    end
  end
endmodule

@@ hdl/quad_coverage_score_map.sv @@
// quad_coverage_score_map: top level, config registers, front/queue/back.
// Depends on qcsm_pkg, qcsm_front, qcsm_fifo, qcsm_back.
// Throughput is set by the back scan, one cell of the clipped box per cycle,
// over two passes for a kept quad, one for a rejected one and none for an empty box.
// Reset: synchronous; a clearing pass over all 2**(clog2(W)+clog2(H)) map cells
// runs before the first request. The receiver cannot stall.
module quad_coverage_score_map #(
  parameter int GRID_WIDTH  = qcsm_pkg::GRID_W_DEF,
  parameter int GRID_HEIGHT = qcsm_pkg::GRID_H_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [qcsm_pkg::CW-1:0] corner1_x, corner1_y, corner2_x, corner2_y,
  input  logic signed [qcsm_pkg::CW-1:0] corner3_x, corner3_y, corner4_x, corner4_y,
  input  logic [qcsm_pkg::QW-1:0] quality,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  output logic done,
  output logic accepted,
  output logic [qcsm_pkg::QW-1:0] image_id,
  output logic [qcsm_pkg::NW-1:0] covered_cells, empty_cells, weaker_cells, written_cells
);
  import qcsm_pkg::*;
  logic [FW-1:0] min_new, max_new, min_bet;
  logic [BW-1:0] bias;
  logic push, full, pop, nonempty, clearing, fbusy;
  quad_t fq, bq;

  assign cfg_ready = 1'b1;
  // front takes requests once the map clear is done
  assign busy = fbusy || clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_new <= 9'd64; max_new <= 9'd230; min_bet <= 9'd128; bias <= 10'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_NEW: min_new <= cfg_data[FW-1:0];
        REG_MAX_NEW: max_new <= cfg_data[FW-1:0];
        REG_MIN_BET: min_bet <= cfg_data[FW-1:0];
        REG_BIAS:    bias <= cfg_data;
        default: ;
      endcase
    end
  end

  qcsm_front #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_front (
    .clk, .rst, .start(start && !clearing), .busy(fbusy),
    .c1x(corner1_x), .c1y(corner1_y), .c2x(corner2_x), .c2y(corner2_y),
    .c3x(corner3_x), .c3y(corner3_y), .c4x(corner4_x), .c4y(corner4_y),
    .quality, .push, .full, .qout(fq));

  qcsm_fifo u_fifo (.clk, .rst, .push, .din(fq), .full, .pop, .nonempty, .dout(bq));

  qcsm_back #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_back (
    .clk, .rst, .nonempty, .qin(bq), .pop, .clearing,
    .min_new, .max_new, .min_bet, .bias, .done, .accepted, .image_id,
    .covered_cells, .empty_cells, .weaker_cells, .written_cells);

  a_push_ok: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_pop_ok: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("pop from empty queue");
  a_wr_rej: assert property (@(posedge clk) disable iff (rst)
    (done && !accepted) |-> (written_cells == '0))
    else $error("rejected quad wrote cells");
endmodule

@@ test/tb_quad_coverage_score_map.sv @@
// tb_quad_coverage_score_map: self-checking testbench for quad_coverage_score_map.
// Drives quads and register writes, predicts every result and checks it field by field.
// Depends on qcsm_pkg and quad_coverage_score_map.
module tb_quad_coverage_score_map;
  timeunit 1ns;
  timeprecision 1ps;
  import qcsm_pkg::*;

  localparam int GW = 256;
  localparam int GH = 256;
  // clearing pass, two full-grid scans per huge quad, small scans otherwise
  localparam longint LIMIT = 4000000;
  localparam int SETTLE = 16;        // idle cycles before a register write
  localparam int TAIL = 25;          // last requests go without gaps

  // one pending request: either a register write or a quad
  typedef struct packed {
    logic                  is_cfg;
    logic [1:0]            idx;
    logic [9:0]            data;
    logic [3:0][CW-1:0]    xs;
    logic [3:0][CW-1:0]    ys;
    logic [QW-1:0]         q;
  } map_req_t;

  typedef struct packed {
    logic          acc;
    logic [QW-1:0] id;
    logic [NW-1:0] cov, emp, wk, wr;
  } map_result_t;

  logic clk = 0, rst = 1;
  logic start = 0, cfg_valid = 0;
  logic signed [CW-1:0] c1x = 0, c1y = 0, c2x = 0, c2y = 0;
  logic signed [CW-1:0] c3x = 0, c3y = 0, c4x = 0, c4y = 0;
  logic [QW-1:0] quality = 0;
  logic [1:0] cfg_index = REG_MIN_NEW;
  logic [9:0] cfg_data = 0;
  logic busy, cfg_ready, done, accepted;
  logic [QW-1:0] image_id;
  logic [NW-1:0] covered_cells, empty_cells, weaker_cells, written_cells;

  quad_coverage_score_map #(.GRID_WIDTH(GW), .GRID_HEIGHT(GH)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .corner1_x(c1x), .corner1_y(c1y), .corner2_x(c2x), .corner2_y(c2y),
    .corner3_x(c3x), .corner3_y(c3y), .corner4_x(c4x), .corner4_y(c4y),
    .quality(quality), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .accepted(accepted),
    .image_id(image_id), .covered_cells(covered_cells), .empty_cells(empty_cells),
    .weaker_cells(weaker_cells), .written_cells(written_cells)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // ---------------------------------------------------------------------
  // Shadow of the score map: occupancy, stored score, id counter, registers.
  // Owner ids are never visible at the ports, so they are not kept.
  // ---------------------------------------------------------------------
  bit            map_vld [GW*GH];
  logic [QW-1:0] map_score [GW*GH];
  logic [QW-1:0] id_ctr = 0;
  longint        min_new = 64, max_new = 230, min_better = 128, bias = 256;

  map_req_t      pending[$];
  map_result_t   expected[$];
  bit            failed = 0;

  // cell centre test against the ordered quad; edges count as inside
  function automatic bit centre_inside(longint px[4], longint py[4], longint cx, longint cy);
    longint c;
    int n;
    for (int k = 0; k < 4; k++) begin
      n = (k + 1) % 4;
      c = (px[n] - px[k]) * (cy - py[k]) - (py[n] - py[k]) * (cx - px[k]);
      if (c < 0) return 0;
    end
    return 1;
  endfunction

  function automatic longint floor_cell(longint v);
    return v >>> 4;
  endfunction

  // Updates the shadow map and returns what the block should report.
  function automatic map_result_t insert_quad(map_req_t r);
    longint px[4], py[4];
    longint t, area, lox, hix, loy, hiy, tot, emp, wk, wr;
    int a;
    bit keep, lo, hi;
    map_result_t res;
    res.id = id_ctr;
    id_ctr = id_ctr + 1;
    for (int k = 0; k < 4; k++) begin
      px[k] = longint'($signed(r.xs[k]));
      py[k] = longint'($signed(r.ys[k]));
    end
    area = 0;
    for (int k = 0; k < 4; k++)
      area += (px[(k+1)%4] - px[k]) * (py[(k+1)%4] + py[k]);
    if (area > 0) begin   // clockwise: swap 2nd and 4th corners
      t = px[1]; px[1] = px[3]; px[3] = t;
      t = py[1]; py[1] = py[3]; py[3] = t;
    end
    lox = px[0]; hix = px[0]; loy = py[0]; hiy = py[0];
    for (int k = 1; k < 4; k++) begin
      if (px[k] < lox) lox = px[k];
      if (px[k] > hix) hix = px[k];
      if (py[k] < loy) loy = py[k];
      if (py[k] > hiy) hiy = py[k];
    end
    lox = floor_cell(lox); if (lox < 0) lox = 0;
    loy = floor_cell(loy); if (loy < 0) loy = 0;
    hix = -floor_cell(-hix); if (hix > GW - 1) hix = GW - 1;
    hiy = -floor_cell(-hiy); if (hiy > GH - 1) hiy = GH - 1;
    tot = 0; emp = 0; wk = 0; wr = 0;
    for (longint i = loy; i <= hiy; i++)
      for (longint j = lox; j <= hix; j++) begin
        a = int'(i * GW + j);
        if (centre_inside(px, py, 16*j + 8, 16*i + 8)) begin
          if (!map_vld[a]) emp++;
          else if (longint'(map_score[a]) * bias < longint'(r.q) * 256) wk++;
          tot++;
        end
      end
    keep = 1;
    if (tot != 0) begin
      lo = emp * 256 < min_new * tot;
      hi = (emp * 256 > max_new * tot) && (emp < tot);
      if ((lo || hi) && (wk * 256 < min_better * tot)) keep = 0;
    end
    if (keep)
      for (longint i = loy; i <= hiy; i++)
        for (longint j = lox; j <= hix; j++) begin
          a = int'(i * GW + j);
          if (centre_inside(px, py, 16*j + 8, 16*i + 8) &&
              (!map_vld[a] || map_score[a] < r.q)) begin
            map_vld[a] = 1;
            map_score[a] = r.q;
            wr++;
          end
        end
    res.acc = keep;
    res.cov = tot[NW-1:0];
    res.emp = emp[NW-1:0];
    res.wk  = wk[NW-1:0];
    res.wr  = wr[NW-1:0];
    return res;
  endfunction

  function automatic void apply_cfg(logic [1:0] idx, logic [9:0] d);
    case (idx)
      REG_MIN_NEW: min_new    = longint'(d[8:0]);
      REG_MAX_NEW: max_new    = longint'(d[8:0]);
      REG_MIN_BET: min_better = longint'(d[8:0]);
      REG_BIAS:    bias       = longint'(d);
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driver: pops the pending queue. A request stays on the ports until its
  // handshake; a register write waits until every result is back and the
  // block has been quiet for a while. Random gap bursts between requests,
  // none for the last TAIL of them.
  // ---------------------------------------------------------------------
  int gap = 0, quiet = 0;

  always @(posedge clk) begin
    bit hold, nxt_start, nxt_cfg;
    map_req_t h;
    if (rst) begin
      start <= 0;
      cfg_valid <= 0;
    end else begin
      hold = 0;
      quiet = (expected.size() == 0) ? quiet + 1 : 0;
      if (start) begin
        if (!busy) begin
          h = pending.pop_front();
          expected = {expected, insert_quad(h)};
          if (pending.size() > TAIL && $urandom_range(0, 9) < 3)
            gap = $urandom_range(1, 10);
        end else hold = 1;
      end
      if (cfg_valid) begin
        if (cfg_ready) begin
          h = pending.pop_front();
          apply_cfg(h.idx, h.data);
          if (pending.size() > TAIL && $urandom_range(0, 9) < 3)
            gap = $urandom_range(1, 10);
        end else hold = 1;
      end
      if (!hold) begin
        nxt_start = 0;
        nxt_cfg = 0;
        if (gap > 0) gap--;
        else if (pending.size() > 0) begin
          h = pending[0];
          if (h.is_cfg) begin
            if (quiet >= SETTLE) begin
              nxt_cfg = 1;
              cfg_index <= h.idx;
              cfg_data <= h.data;
            end
          end else begin
            nxt_start = 1;
            c1x <= h.xs[0]; c1y <= h.ys[0];
            c2x <= h.xs[1]; c2y <= h.ys[1];
            c3x <= h.xs[2]; c3y <= h.ys[2];
            c4x <= h.xs[3]; c4y <= h.ys[3];
            quality <= h.q;
          end
        end
        start <= nxt_start;
        cfg_valid <= nxt_cfg;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: each done strobe is checked against the oldest expectation.
  // ---------------------------------------------------------------------
  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
      failed = 1;
    end
  endtask

  always @(posedge clk) begin
    map_result_t e;
    if (!rst && done) begin
      if (expected.size() == 0) begin
        $display("%0t unexpected result: expected none, actual id %0d", $time, image_id);
        failed = 1;
      end else begin
        e = expected.pop_front();
        check_field("accepted", e.acc, accepted);
        check_field("image_id", e.id, image_id);
        check_field("covered_cells", e.cov, covered_cells);
        check_field("empty_cells", e.emp, empty_cells);
        check_field("weaker_cells", e.wk, weaker_cells);
        check_field("written_cells", e.wr, written_cells);
      end
    end
  end

  // run guard
  longint cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** quad_coverage_score_map: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------
  task automatic push_cfg(logic [1:0] idx, logic [9:0] d);
    map_req_t r;
    r = '0;
    r.is_cfg = 1;
    r.idx = idx;
    r.data = d;
    pending = {pending, r};
  endtask

  task automatic push_cfg_all(int mn, int mx, int mb, int b);
    push_cfg(REG_MIN_NEW, 10'(mn));
    push_cfg(REG_MAX_NEW, 10'(mx));
    push_cfg(REG_MIN_BET, 10'(mb));
    push_cfg(REG_BIAS, 10'(b));
  endtask

  task automatic push_quad(int x0, int y0, int x1, int y1, int x2, int y2,
                           int x3, int y3, int q);
    map_req_t r;
    r = '0;
    r.xs[0] = CW'(x0); r.ys[0] = CW'(y0);
    r.xs[1] = CW'(x1); r.ys[1] = CW'(y1);
    r.xs[2] = CW'(x2); r.ys[2] = CW'(y2);
    r.xs[3] = CW'(x3); r.ys[3] = CW'(y3);
    r.q = QW'(q);
    pending = {pending, r};
  endtask

  // axis box from (x0,y0) to (x1,y1) in 1/16 cells, either winding
  task automatic push_box(int x0, int y0, int x1, int y1, bit cw, int q);
    if (cw) push_quad(x0, y0, x0, y1, x1, y1, x1, y0, q);
    else    push_quad(x0, y0, x1, y0, x1, y1, x0, y1, q);
  endtask

  // well-formed jittered quad around a centre, random winding and start corner
  task automatic push_random_quad();
    int cx, cy, hw, hh, q, rot;
    int xs[4], ys[4], o[4];
    if ($urandom_range(0, 9) == 0) begin   // near the far x edge of the grid
      cx = 16 * $urandom_range(235, 265);
      cy = 16 * $urandom_range(0, 265);
    end else begin
      cx = 16 * $urandom_range(0, 60) - 160;
      cy = 16 * $urandom_range(0, 60) - 160;
    end
    hw = $urandom_range(0, 200);
    hh = $urandom_range(0, 200);
    xs = '{cx - hw, cx + hw, cx + hw, cx - hw};
    ys = '{cy - hh, cy - hh, cy + hh, cy + hh};
    for (int k = 0; k < 4; k++) begin
      xs[k] += $urandom_range(0, 16) - 8;
      ys[k] += $urandom_range(0, 16) - 8;
    end
    rot = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++)
      o[k] = $urandom_range(0, 1) ? (rot + k) % 4 : (rot + 4 - k) % 4;
    case ($urandom_range(0, 3))
      0: q = $urandom_range(0, 65535);
      1: q = 16'hFFFF;
      2: q = 0;
      default: q = 1000 * $urandom_range(1, 40);
    endcase
    if (o[1] == o[2] || o[1] == o[3] || o[0] == o[2]) begin
      // mixed winding draw: fall back to a consistent one
      for (int k = 0; k < 4; k++) o[k] = (rot + k) % 4;
    end
    push_quad(xs[o[0]], ys[o[0]], xs[o[1]], ys[o[1]], xs[o[2]], ys[o[2]],
              xs[o[3]], ys[o[3]], q);
  endtask

  // four unrelated corners in a small window: concave or twisted shapes
  task automatic push_scatter_quad();
    int bx, by;
    bx = 16 * $urandom_range(0, 50) - 100;
    by = 16 * $urandom_range(0, 50) - 100;
    push_quad(bx + $urandom_range(0, 400), by + $urandom_range(0, 400),
              bx + $urandom_range(0, 400), by + $urandom_range(0, 400),
              bx + $urandom_range(0, 400), by + $urandom_range(0, 400),
              bx + $urandom_range(0, 400), by + $urandom_range(0, 400),
              $urandom_range(0, 65535));
  endtask

  // full 17-bit corners; the clipped box may be the whole grid
  task automatic push_wild_quad();
    push_quad($signed(17'($urandom)), $signed(17'($urandom)),
              $signed(17'($urandom)), $signed(17'($urandom)),
              $signed(17'($urandom)), $signed(17'($urandom)),
              $signed(17'($urandom)), $signed(17'($urandom)),
              $urandom_range(0, 65535));
  endtask

  initial begin
    int mode;
    repeat (7) @(posedge clk);
    rst <= 0;

    // directed: defaults written explicitly, then the special cases
    push_cfg_all(64, 230, 128, 256);
    push_box(64, 64, 192, 192, 0, 1000);          // fresh area, all empty
    push_box(64, 64, 192, 192, 1, 1000);          // same cells, not better: rejected
    push_box(64, 64, 192, 192, 1, 65535);         // all weaker: kept, overwrites
    push_box(128, 128, 256, 256, 0, 500);         // partial overlap
    push_box(640, 640, 720, 720, 0, 0);           // zero quality on empty cells
    push_box(64, 64, 640, 640, 0, 70);            // mostly new, small overlap: too new
    push_quad(-65536, -65536, -65536, -65536, -65536, -65536,
              -65536, -65536, 9);                 // far outside, low corner
    push_quad(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 9);
    push_quad(321, 321, 323, 321, 321, 323, 321, 323, 77);   // no centre covered
    push_box(488, 488, 552, 552, 1, 400);         // centres exactly on edges
    push_quad(800, 800, 900, 820, 820, 900, 860, 860, 300); // concave
    push_quad(1000, 1000, 1100, 1100, 1100, 1000, 1000, 1100, 300); // bow tie
    push_quad(-65536, -65536, 65535, -65536, 65535, 65535,
              -65536, 65535, 30000);              // whole grid
    push_box(3900, 3900, 4200, 4200, 0, 65535);   // clipped at far corner

    // extremes: everything passes the gain test, bias zero
    push_cfg_all(0, 511, 0, 0);
    for (int n = 0; n < 40; n++) push_random_quad();
    push_wild_quad();
    push_scatter_quad();

    // opposite extremes: nearly everything fails, bias at its top
    push_cfg_all(256, 0, 256, 1023);
    for (int n = 0; n < 35; n++) begin
      mode = $urandom_range(0, 9);
      if (mode == 0) push_scatter_quad();
      else push_random_quad();
    end
    push_wild_quad();

    // random settings
    push_cfg_all($urandom_range(0, 300), $urandom_range(100, 511),
                 $urandom_range(0, 300), $urandom_range(0, 1023));
    for (int n = 0; n < 40; n++) begin
      mode = $urandom_range(0, 9);
      if (mode == 0) push_scatter_quad();
      else push_random_quad();
    end
    push_wild_quad();
    for (int n = 0; n < 8; n++) push_random_quad();

    wait (pending.size() == 0 && !start && !cfg_valid && expected.size() == 0);
    repeat (40) @(posedge clk);
    if (!failed)
      $display("** quad_coverage_score_map: PASSED **");
    else
      $display("** quad_coverage_score_map: FAILED **");
    $finish;
  end
endmodule

@@ sim.f @@
hdl/qcsm_pkg.sv
hdl/qcsm_front.sv
hdl/qcsm_fifo.sv
hdl/qcsm_back.sv
hdl/quad_coverage_score_map.sv
test/tb_quad_coverage_score_map.sv
